[design/dda_line_rasterizer_macros.svh]
// assertion macros shared by the line rasterizer modules
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DDA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dda_pkg.sv]
// shared types and constants for the dda line rasterizer
package dda_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 600;

    localparam int COORD_W   = 10;
    localparam int POS_W     = COORD_W + 1;
    localparam int FIX_W     = 28;
    localparam int RND_W     = FIX_W + 2;
    localparam int SCR_W     = 10;
    localparam int COLOR_W   = 4;
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    localparam logic [COLOR_W-1:0] COLOR_RESET = COLOR_W'(14);

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // screen offsets in fixed point, with the rounding half folded in
    localparam logic signed [RND_W-1:0] X_OFS_FIX =
        RND_W'((SCREEN_WIDTH / 2) * (1 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));
    localparam logic signed [RND_W-1:0] Y_OFS_FIX =
        RND_W'((SCREEN_HEIGHT / 2) * (1 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));

    localparam logic signed [POS_W-1:0] X_OFS_INT = POS_W'(SCREEN_WIDTH / 2);
    localparam logic signed [POS_W-1:0] Y_OFS_INT = POS_W'(SCREEN_HEIGHT / 2);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } st_t;

    typedef struct packed {
        logic               start;
        logic               negate;
        logic [COORD_W-1:0] dividend;
        logic [COORD_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                    done;
        logic signed [FIX_W-1:0] quotient;
    } div_rsp_t;

endpackage

[design/dda_if.sv]
// channel interfaces for requests, pixels and configuration

interface dda_req_if import dda_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;

    modport source (output valid, req_type, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_pix_if import dda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCR_W-1:0]   screen_x;
    logic [SCR_W-1:0]   screen_y;
    logic [COLOR_W-1:0] color;
    logic               last_pixel;

    modport source (output valid, screen_x, screen_y, color, last_pixel, input ready);
    modport sink   (input valid, screen_x, screen_y, color, last_pixel, output ready);
endinterface

interface dda_cfg_if import dda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink   (input valid, pixel_color, output ready);
endinterface

[design/dda_div.sv]
// iterative restoring divider for the slope, one quotient bit per cycle
`include "dda_line_rasterizer_macros.svh"

module dda_div import dda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic                    neg_reg;
    logic [COORD_W:0]        rem_reg;
    logic [COORD_W-1:0]      divisor_reg;
    logic [QUOT_W-2:0]       q_reg;
    logic signed [FIX_W-1:0] quot_reg;

    logic                    ge;
    logic [COORD_W:0]        diff;
    logic [QUOT_W-1:0]       q_full;
    logic [FIX_W-1:0]        q_ext;
    logic                    last_iter;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, divisor_reg};
        diff      = ge ? rem_reg - {1'b0, divisor_reg} : rem_reg;
        q_full    = {q_reg, ge};
        q_ext     = FIX_W'(q_full);
        last_iter = busy_reg && (cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_iter;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (last_iter)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg     <= {1'b0, cmd.dividend};
            divisor_reg <= cmd.divisor;
            neg_reg     <= cmd.negate;
            q_reg       <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= {diff[COORD_W-1:0], 1'b0};
            q_reg   <= {q_reg[QUOT_W-3:0], ge};
            if (last_iter)
            begin
                quot_reg <= neg_reg ? -q_ext : q_ext;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

    `DDA_ASSERT_IMP(a_start_when_free, cmd.start, !busy_reg, "divider started while busy")
    `DDA_ASSERT_NXT(a_busy_after_start, cmd.start, busy_reg, "divider did not start")
    `DDA_ASSERT_NXT(a_done_single, done_reg, !done_reg && !busy_reg, "divider done not a pulse")

endmodule

[design/dda_pixel.sv]
// converts major position and minor accumulator to rounded screen coordinates
module dda_pixel import dda_pkg::*;
(
    input  logic                    steep,
    input  logic signed [POS_W-1:0] major_pos,
    input  logic signed [FIX_W-1:0] minor_acc,
    output logic [SCR_W-1:0]        screen_x,
    output logic [SCR_W-1:0]        screen_y
);

    logic signed [RND_W-1:0] acc_ext;
    logic signed [RND_W-1:0] t_c;
    logic signed [RND_W-1:0] floor_c;
    logic signed [RND_W-1:0] trunc_c;
    logic                    fix_up;
    logic signed [POS_W-1:0] major_x;
    logic signed [POS_W-1:0] major_y;

    always_comb
    begin
        acc_ext = RND_W'(minor_acc);
        t_c     = steep ? acc_ext + X_OFS_FIX : Y_OFS_FIX - acc_ext;
        // truncate toward zero
        floor_c = t_c >>> FRAC_BITS;
        fix_up  = t_c[RND_W-1] && (t_c[FRAC_BITS-1:0] != '0);
        trunc_c = floor_c + {{(RND_W-1){1'b0}}, fix_up};
        major_x = major_pos + X_OFS_INT;
        major_y = Y_OFS_INT - major_pos;
        screen_x = steep ? trunc_c[SCR_W-1:0] : major_x[SCR_W-1:0];
        screen_y = steep ? major_y[SCR_W-1:0] : trunc_c[SCR_W-1:0];
    end

endmodule

[design/dda_line_rasterizer.sv]
// top level of the dda line rasterizer: sequencer, line state and pixel output
//
// req carries one transaction per item. req_type 0 loads a line from x_start,
// y_start, x_end, y_end and emits nothing; req_type 1 emits the next pixel on
// pix, with last_pixel set on the final one. a step with no line loaded emits
// nothing. cfg writes the 4-bit pixel color, taken every cycle.
// a step's pixel is registered and is on pix the cycle after acceptance,
// so steps sustain one pixel per cycle while pix keeps up.
// a start with a nonzero minor delta waits on the divider: the slope comes
// from a restoring divider, one quotient bit per cycle over 17 bits.
// horizontal, vertical and single-point lines need no division.
// req.ready is low while the divider runs.
// pix is held in an output register; if the receiver stalls with a pixel
// waiting, req.ready drops until that pixel is taken.
// reset clears the line state and output valid, and sets the color to 14.
`include "dda_line_rasterizer_macros.svh"

module dda_line_rasterizer import dda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dda_req_if.sink   req,
    dda_pix_if.source pix,
    dda_cfg_if.sink   cfg
);

    st_t                     state_reg;
    st_t                     state_next;
    logic                    line_active_reg;
    logic                    steep_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [POS_W-1:0] limit_reg;
    logic signed [FIX_W-1:0] acc_reg;
    logic signed [FIX_W-1:0] inc_reg;
    logic [COLOR_W-1:0]      color_cfg_reg;

    logic                    pix_valid_reg;
    logic [SCR_W-1:0]        sx_reg;
    logic [SCR_W-1:0]        sy_reg;
    logic [COLOR_W-1:0]      pcolor_reg;
    logic                    plast_reg;

    logic                    req_fire;
    logic                    start_fire;
    logic                    step_fire;
    logic                    step_last;

    logic signed [POS_W-1:0] xa;
    logic signed [POS_W-1:0] ya;
    logic signed [POS_W-1:0] xb;
    logic signed [POS_W-1:0] yb;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic [POS_W-1:0]        adx;
    logic [POS_W-1:0]        ady;
    logic                    shallow;
    logic                    swap;
    logic                    minor_zero;
    logic signed [POS_W-1:0] first_major;
    logic signed [POS_W-1:0] last_major;
    logic signed [POS_W-1:0] first_minor;
    logic signed [FIX_W-1:0] acc_start;

    logic [SCR_W-1:0]        sx_c;
    logic [SCR_W-1:0]        sy_c;

    div_cmd_t                div_cmd;
    div_rsp_t                div_rsp;

    assign req.ready = (state_reg == ST_IDLE) && (!pix_valid_reg || pix.ready);
    assign cfg.ready = 1'b1;

    assign req_fire   = req.valid && req.ready;
    assign start_fire = req_fire && (req.req_type == REQ_START);
    assign step_fire  = req_fire && (req.req_type == REQ_STEP) && line_active_reg;
    assign step_last  = pos_reg >= limit_reg;

    // line setup: order endpoints along the major axis
    always_comb
    begin
        xa  = POS_W'(req.x_start);
        ya  = POS_W'(req.y_start);
        xb  = POS_W'(req.x_end);
        yb  = POS_W'(req.y_end);
        dx  = xb - xa;
        dy  = yb - ya;
        adx = dx[POS_W-1] ? -dx : dx;
        ady = dy[POS_W-1] ? -dy : dy;
        shallow = (dy == '0) || ((dx != '0) && (ady <= adx));
        if (shallow)
        begin
            swap        = xa > xb;
            first_major = swap ? xb : xa;
            last_major  = swap ? xa : xb;
            first_minor = swap ? yb : ya;
            minor_zero  = dy == '0;
            div_cmd.dividend = ady[COORD_W-1:0];
            div_cmd.divisor  = adx[COORD_W-1:0];
        end
        else
        begin
            swap        = ya > yb;
            first_major = swap ? yb : ya;
            last_major  = swap ? ya : yb;
            first_minor = swap ? xb : xa;
            minor_zero  = dx == '0;
            div_cmd.dividend = adx[COORD_W-1:0];
            div_cmd.divisor  = ady[COORD_W-1:0];
        end
        acc_start = {{(FIX_W-POS_W-FRAC_BITS){first_minor[POS_W-1]}}, first_minor,
                     {FRAC_BITS{1'b0}}};
        div_cmd.negate = dx[POS_W-1] ^ dy[POS_W-1];
        div_cmd.start  = start_fire && !minor_zero;
    end

    dda_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    dda_pixel u_pixel
    (
        .steep     (steep_reg),
        .major_pos (pos_reg),
        .minor_acc (acc_reg),
        .screen_x  (sx_c),
        .screen_y  (sy_c)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (div_cmd.start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            pix_valid_reg   <= 1'b0;
            color_cfg_reg   <= COLOR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                color_cfg_reg <= cfg.pixel_color;
            end
            if (start_fire)
            begin
                line_active_reg <= 1'b1;
            end
            else if (step_fire && step_last)
            begin
                line_active_reg <= 1'b0;
            end
            if (step_fire)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_fire)
        begin
            steep_reg <= !shallow;
            pos_reg   <= first_major;
            limit_reg <= last_major;
            acc_reg   <= acc_start;
            if (minor_zero)
            begin
                inc_reg <= '0;
            end
        end
        else if (step_fire && !step_last)
        begin
            pos_reg <= pos_reg + POS_W'(1);
            acc_reg <= acc_reg + inc_reg;
        end
        if (div_rsp.done)
        begin
            inc_reg <= div_rsp.quotient;
        end
        if (step_fire)
        begin
            sx_reg     <= sx_c;
            sy_reg     <= sy_c;
            pcolor_reg <= color_cfg_reg;
            plast_reg  <= step_last;
        end
    end

    assign pix.valid      = pix_valid_reg;
    assign pix.screen_x   = sx_reg;
    assign pix.screen_y   = sy_reg;
    assign pix.color      = pcolor_reg;
    assign pix.last_pixel = plast_reg;

    `DDA_ASSERT_IMP(a_done_in_div, div_rsp.done, state_reg == ST_DIV, "slope ready outside division")
    `DDA_ASSERT_NXT(a_step_advance, step_fire && !step_last, pos_reg == $past(pos_reg) + POS_W'(1), "major position did not advance")
    `DDA_ASSERT_NXT(a_last_clears, step_fire && step_last, !line_active_reg && pix_valid_reg && plast_reg, "final pixel did not end the line")

endmodule
